### sv/cil_pkg.sv
// Shared types and constants for the column isosurface level block.
`timescale 1ns / 1ps

package cil_pkg;

  // Default width of a signed fixed-point value.
  localparam int DEFAULT_VALUE_BITS = 32;

  // Reset pattern of the missing-value register, sign extended to 64 bits.
  localparam logic [63:0] MISSING_RESET = 64'hFFFF_FFFF_8000_0000;

  // Configuration register indexes.
  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MODE    = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ISO     = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MISSING = 2'd2;

  // Column selection modes.
  typedef enum logic [1:0] {
    MODE_ISO   = 2'd0,
    MODE_FIRST = 2'd1,
    MODE_LAST  = 2'd2
  } mode_t;

  // Decision flags for one adjacent pair of samples in iso mode.
  typedef struct packed {
    logic take_cur;    // previous missing, current equals the iso value
    logic take_prev;   // current missing, previous equals the iso value
    logic bracket;     // both present and the iso value lies between them
    logic equal_vals;  // both samples hold the same value
    logic negate;      // interpolation offset is subtracted from the level
  } pair_flags_t;

endpackage

### sv/cil_pair.sv
// Pair classifier: missing-value rules, bracketing test and operand magnitudes.
`timescale 1ns / 1ps

module cil_pair import cil_pkg::*; #(
  parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
  input  logic signed [VALUE_BITS-1:0] prev_val,
  input  logic signed [VALUE_BITS-1:0] cur_val,
  input  logic signed [VALUE_BITS-1:0] prev_lvl,
  input  logic signed [VALUE_BITS-1:0] cur_lvl,
  input  logic signed [VALUE_BITS-1:0] iso_val,
  input  logic signed [VALUE_BITS-1:0] missing_val,
  output pair_flags_t                  flags,
  output logic        [VALUE_BITS-1:0] lvl_mag,
  output logic        [VALUE_BITS-1:0] iso_mag,
  output logic        [VALUE_BITS-1:0] val_mag
);

  localparam int W = VALUE_BITS;

  // Magnitude of a - b; both differences are formed one bit wider so they are exact.
  function automatic logic [W-1:0] mag_diff(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] ab;
    logic [W:0] ba;
    ab = {a[W-1], a} - {b[W-1], b};
    ba = {b[W-1], b} - {a[W-1], a};
    mag_diff = ab[W] ? ba[W-1:0] : ab[W-1:0];
  endfunction

  logic prev_miss, cur_miss;
  logic neg_lvl, neg_iso, neg_val;
  logic prev_le_iso, iso_le_cur, cur_le_iso, iso_le_prev;

  always_comb begin
    prev_miss   = (prev_val == missing_val);
    cur_miss    = (cur_val == missing_val);
    neg_lvl     = (cur_lvl < prev_lvl);
    neg_iso     = (iso_val < prev_val);
    neg_val     = (cur_val < prev_val);
    prev_le_iso = !neg_iso;
    iso_le_prev = (iso_val <= prev_val);
    iso_le_cur  = (iso_val <= cur_val);
    cur_le_iso  = (cur_val <= iso_val);

    flags.take_cur   = prev_miss && !cur_miss && (iso_val == cur_val);
    flags.take_prev  = cur_miss && !prev_miss && (iso_val == prev_val);
    flags.bracket    = !prev_miss && !cur_miss &&
                       ((prev_le_iso && iso_le_cur) || (cur_le_iso && iso_le_prev));
    flags.equal_vals = (prev_val == cur_val);
    flags.negate     = neg_lvl ^ neg_iso ^ neg_val;

    lvl_mag = mag_diff(cur_lvl, prev_lvl);
    iso_mag = mag_diff(iso_val, prev_val);
    val_mag = mag_diff(cur_val, prev_val);
  end

endmodule

### sv/cil_muldiv.sv
// Iterative multiply, divide and offset unit built around one shared adder.
`timescale 1ns / 1ps

module cil_muldiv import cil_pkg::*; #(
  parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] mul_a,
  input  logic [VALUE_BITS-1:0] mul_b,
  input  logic [VALUE_BITS-1:0] divisor,
  input  logic [VALUE_BITS-1:0] base,
  input  logic                  negate,
  output logic                  done,
  output logic [VALUE_BITS-1:0] result
);

  localparam int W  = VALUE_BITS;
  localparam int CW = $clog2(W);
  localparam logic [CW-1:0] LAST_STEP = CW'(W - 1);

  typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV, MD_FIX} md_state_t;

  md_state_t     state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  hi_r, hi_nxt;
  logic [W-1:0]  lo_r, lo_nxt;
  logic [W-1:0]  mcand_r, mcand_nxt;
  logic [W-1:0]  dvsr_r, dvsr_nxt;
  logic [W-1:0]  base_r, base_nxt;
  logic          neg_r, neg_nxt;
  logic          done_r, done_nxt;
  logic [W-1:0]  result_r, result_nxt;

  logic [W:0]    add_x, add_y;
  logic          add_cin;
  logic [W+1:0]  add_sum;

  // The one adder: accumulate in the multiply, trial subtract in the divide,
  // add or subtract the quotient from the base level at the end.
  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_cin = 1'b0;
    unique case (state_r)
      MD_MUL: begin
        add_x = {1'b0, hi_r};
        add_y = lo_r[0] ? {1'b0, mcand_r} : '0;
      end
      MD_DIV: begin
        add_x   = {hi_r, lo_r[W-1]};
        add_y   = ~{1'b0, dvsr_r};
        add_cin = 1'b1;
      end
      MD_FIX: begin
        add_x   = {1'b0, base_r};
        add_y   = neg_r ? ~{1'b0, lo_r} : {1'b0, lo_r};
        add_cin = neg_r;
      end
      default: ;
    endcase
    add_sum = {1'b0, add_x} + {1'b0, add_y} + {{(W + 1){1'b0}}, add_cin};
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    hi_nxt     = hi_r;
    lo_nxt     = lo_r;
    mcand_nxt  = mcand_r;
    dvsr_nxt   = dvsr_r;
    base_nxt   = base_r;
    neg_nxt    = neg_r;
    done_nxt   = 1'b0;
    result_nxt = result_r;
    unique case (state_r)
      MD_IDLE: begin
        if (start) begin
          hi_nxt    = '0;
          lo_nxt    = mul_b;
          mcand_nxt = mul_a;
          dvsr_nxt  = divisor;
          base_nxt  = base;
          neg_nxt   = negate;
          cnt_nxt   = '0;
          state_nxt = MD_MUL;
        end
      end
      MD_MUL: begin
        hi_nxt  = add_sum[W:1];
        lo_nxt  = {add_sum[0], lo_r[W-1:1]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          cnt_nxt   = '0;
          state_nxt = MD_DIV;
        end
      end
      MD_DIV: begin
        // The remainder stays below the divisor, so W bits hold it.
        hi_nxt  = add_sum[W+1] ? add_sum[W-1:0] : {hi_r[W-2:0], lo_r[W-1]};
        lo_nxt  = {lo_r[W-2:0], add_sum[W+1]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          cnt_nxt   = '0;
          state_nxt = MD_FIX;
        end
      end
      MD_FIX: begin
        result_nxt = add_sum[W-1:0];
        done_nxt   = 1'b1;
        state_nxt  = MD_IDLE;
      end
      default: state_nxt = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MD_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
    hi_r     <= hi_nxt;
    lo_r     <= lo_nxt;
    mcand_r  <= mcand_nxt;
    dvsr_r   <= dvsr_nxt;
    base_r   <= base_nxt;
    neg_r    <= neg_nxt;
    result_r <= result_nxt;
  end

  assign done   = done_r;
  assign result = result_r;

endmodule

### sv/column_isosurface_level.sv
// Top level of the column isosurface level search with first and last value modes.
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Beat contents
// in_       input      in_valid / in_stall  sample value, level coordinate, column end
// out_      output     out_valid/out_stall  surface value, found flag
// cfg_      input      cfg_valid/cfg_ready  register index, write data
//
// A sample that needs no interpolation is taken without a stall, so such
// samples stream one per cycle while neither the divider nor the output
// register holds the input. A sample that closes a bracketing pair in iso
// mode with two different values starts the shared multiply-divide unit and
// stalls the input through VALUE_BITS shift-add steps, VALUE_BITS restoring
// divide steps and one offset step, all through one adder; a registered done
// step hands back the finished level. This happens at most once per column.
// Reset is synchronous and active low; it restores the register defaults and
// an empty column. The result beat sits in an output register; while it waits
// on out_stall the input is stalled too, and it frees the input in the cycle
// in which it drains.

module column_isosurface_level import cil_pkg::*; #(
  parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // Sample channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [VALUE_BITS-1:0] in_sample_value,
  input  logic signed [VALUE_BITS-1:0] in_level_coord,
  input  logic                         in_column_end,
  // Result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [VALUE_BITS-1:0] out_surface_value,
  output logic                         out_found,
  // Configuration write channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [VALUE_BITS-1:0]        cfg_data
);

  localparam int W = VALUE_BITS;

  // Configuration registers.
  mode_t               mode_r;
  logic signed [W-1:0] iso_r;
  logic signed [W-1:0] miss_r;

  // Column state.
  logic signed [W-1:0] prev_val_r, prev_val_nxt;
  logic signed [W-1:0] prev_lvl_r, prev_lvl_nxt;
  logic                have_prev_r, have_prev_nxt;
  logic                column_done_r, column_done_nxt;
  logic                result_set_r, result_set_nxt;
  logic signed [W-1:0] column_result_r, column_result_nxt;

  // Sequencing and output register.
  logic                busy_r, busy_nxt;
  logic                pend_end_r, pend_end_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic signed [W-1:0] out_value_r, out_value_nxt;
  logic                out_found_r, out_found_nxt;

  logic                in_accept;
  logic                md_start;
  logic                md_done;
  logic [W-1:0]        md_result;
  pair_flags_t         pair;
  logic [W-1:0]        lvl_mag, iso_mag, val_mag;

  cil_pair #(
    .VALUE_BITS(VALUE_BITS)
  ) u_pair (
    .prev_val   (prev_val_r),
    .cur_val    (in_sample_value),
    .prev_lvl   (prev_lvl_r),
    .cur_lvl    (in_level_coord),
    .iso_val    (iso_r),
    .missing_val(miss_r),
    .flags      (pair),
    .lvl_mag    (lvl_mag),
    .iso_mag    (iso_mag),
    .val_mag    (val_mag)
  );

  // The quotient (level span * iso offset) / value span never exceeds the level
  // span, so the interpolated level always lies between the two levels.
  cil_muldiv #(
    .VALUE_BITS(VALUE_BITS)
  ) u_muldiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (md_start),
    .mul_a  (lvl_mag),
    .mul_b  (iso_mag),
    .divisor(val_mag),
    .base   (prev_lvl_r),
    .negate (pair.negate),
    .done   (md_done),
    .result (md_result)
  );

  // A new sample waits while the divider runs, or while a result is stuck in
  // the output register; a result in the register that drains this cycle frees it.
  assign in_stall  = busy_r || (out_valid_r && out_stall);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    prev_val_nxt      = prev_val_r;
    prev_lvl_nxt      = prev_lvl_r;
    have_prev_nxt     = have_prev_r;
    column_done_nxt   = column_done_r;
    result_set_nxt    = result_set_r;
    column_result_nxt = column_result_r;
    busy_nxt          = busy_r;
    pend_end_nxt      = pend_end_r;
    out_valid_nxt     = out_valid_r;
    out_value_nxt     = out_value_r;
    out_found_nxt     = out_found_r;
    md_start          = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (in_accept) begin
      unique case (mode_r)
        MODE_ISO: begin
          if (have_prev_r && !column_done_r) begin
            // A missing neighbor still lets an exact hit set the level, but
            // the search goes on past it.
            if (pair.take_cur) begin
              column_result_nxt = in_level_coord;
              result_set_nxt    = 1'b1;
            end
            if (pair.take_prev) begin
              column_result_nxt = prev_lvl_r;
              result_set_nxt    = 1'b1;
            end
            if (pair.bracket) begin
              column_done_nxt = 1'b1;
              if (pair.equal_vals) begin
                column_result_nxt = prev_lvl_r;
                result_set_nxt    = 1'b1;
              end else begin
                md_start = 1'b1;
              end
            end
          end
        end
        MODE_FIRST: begin
          if (!column_done_r && (in_sample_value != miss_r)) begin
            column_result_nxt = in_sample_value;
            result_set_nxt    = 1'b1;
            column_done_nxt   = 1'b1;
          end
        end
        MODE_LAST: begin
          if (in_sample_value != miss_r) begin
            column_result_nxt = in_sample_value;
            result_set_nxt    = 1'b1;
          end
        end
        default: ;
      endcase

      prev_val_nxt  = in_sample_value;
      prev_lvl_nxt  = in_level_coord;
      have_prev_nxt = 1'b1;
      busy_nxt      = md_start;

      if (in_column_end) begin
        // The column closes now; an interpolation still running delivers
        // its beat straight from the divider when it finishes.
        if (md_start) begin
          pend_end_nxt = 1'b1;
        end else begin
          out_valid_nxt = 1'b1;
          out_value_nxt = result_set_nxt ? column_result_nxt : miss_r;
          out_found_nxt = result_set_nxt;
        end
        have_prev_nxt   = 1'b0;
        column_done_nxt = 1'b0;
        result_set_nxt  = 1'b0;
      end
    end

    if (md_done) begin
      busy_nxt     = 1'b0;
      pend_end_nxt = 1'b0;
      if (pend_end_r) begin
        out_valid_nxt = 1'b1;
        out_value_nxt = md_result;
        out_found_nxt = 1'b1;
      end else begin
        column_result_nxt = md_result;
        result_set_nxt    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_ISO;
      iso_r         <= '0;
      miss_r        <= MISSING_RESET[W-1:0];
      prev_val_r    <= '0;
      prev_lvl_r    <= '0;
      have_prev_r   <= 1'b0;
      column_done_r <= 1'b0;
      result_set_r  <= 1'b0;
      busy_r        <= 1'b0;
      pend_end_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_MODE:    mode_r <= mode_t'(cfg_data[1:0]);
          CFG_ISO:     iso_r  <= cfg_data;
          CFG_MISSING: miss_r <= cfg_data;
          default: ;
        endcase
      end
      prev_val_r    <= prev_val_nxt;
      prev_lvl_r    <= prev_lvl_nxt;
      have_prev_r   <= have_prev_nxt;
      column_done_r <= column_done_nxt;
      result_set_r  <= result_set_nxt;
      busy_r        <= busy_nxt;
      pend_end_r    <= pend_end_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    column_result_r <= column_result_nxt;
    out_value_r     <= out_value_nxt;
    out_found_r     <= out_found_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_surface_value = out_value_r;
  assign out_found         = out_found_r;

  // The divider only reports back while the top level waits for it.
  a_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    md_done |-> busy_r)
    else $error("divider finished while no interpolation was pending");

  // An interpolation inside an open column marks that column as settled.
  a_busy_column_done: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !pend_end_r) |-> column_done_r)
    else $error("interpolation running in a column that is not settled");

  // Only iso mode ever starts the divider.
  a_start_iso_only: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy_r) |-> ($past(mode_r) == MODE_ISO))
    else $error("divider started outside iso mode");

  // A mid-column interpolation leaves a set result behind.
  a_done_sets_result: assert property (@(posedge clk) disable iff (!rst_n)
    (md_done && !pend_end_r) |=> result_set_r)
    else $error("interpolated level not recorded");

endmodule

### verif/tb_column_isosurface_level.sv
// Self-checking testbench for the column isosurface level search block.
`timescale 1ns / 1ps

module tb_column_isosurface_level;
  import cil_pkg::*;

  localparam int VBITS = 32;
  // Longest busy stretch of the block: one multiply-divide pass plus margin.
  localparam int DRAIN_CYCLES = 2 * VBITS + 16;
  // Cycles without any accepted beat on any channel before the run is given up.
  localparam int STALL_LIMIT = 4000;
  // Mode code 3 is not used by the block; it must select nothing.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [VBITS-1:0] Q_ONE = 32'h0001_0000;
  localparam logic [VBITS-1:0] Q_MIN = 32'h8000_0000;
  localparam logic [VBITS-1:0] Q_MAX = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [VBITS-1:0] surface;
    logic             found;
  } column_result_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                         in_valid;
  logic                         in_stall;
  logic signed [VBITS-1:0]      in_sample_value;
  logic signed [VBITS-1:0]      in_level_coord;
  logic                         in_column_end;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic signed [VBITS-1:0]      out_surface_value;
  logic                         out_found;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [CFG_INDEX_BITS-1:0]    cfg_index;
  logic [VBITS-1:0]             cfg_data;

  column_isosurface_level #(
    .VALUE_BITS(VBITS)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample_value  (in_sample_value),
    .in_level_coord   (in_level_coord),
    .in_column_end    (in_column_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_surface_value(out_surface_value),
    .out_found        (out_found),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #6 clk = ~clk;

  // Shadow copy of the configuration registers.
  logic [1:0]       cur_mode;
  logic [VBITS-1:0] iso_reg;
  logic [VBITS-1:0] miss_reg;

  // Shadow copy of the column search state.
  logic [VBITS-1:0] prev_sample;
  logic [VBITS-1:0] prev_level;
  logic             have_prev;
  logic             column_done;
  logic [VBITS-1:0] col_result;
  logic             result_set;

  // Column results still owed by the block, oldest first.
  column_result_t pending_columns[$];

  int mismatch_count = 0;
  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles = 0;

  // ---------------------------------------------------------------------------
  // Column search predictor
  // ---------------------------------------------------------------------------

  function void clear_column();
    have_prev   = 1'b0;
    column_done = 1'b0;
    result_set  = 1'b0;
    col_result  = miss_reg;
  endfunction

  // Level where the straight line through (vp, lp) and (vc, lc) meets the iso
  // value. The product is formed at full width so nothing overflows, and the
  // signed division truncates toward zero as the block does.
  function logic [VBITS-1:0] crossing_level(logic [VBITS-1:0] lp, logic [VBITS-1:0] vp,
                                            logic [VBITS-1:0] lc, logic [VBITS-1:0] vc);
    logic signed [127:0] dl, di, dv, offset;
    dl = $signed(lc) - $signed(lp);
    di = $signed(iso_reg) - $signed(vp);
    dv = $signed(vc) - $signed(vp);
    offset = (dl * di) / dv;
    return lp + offset[VBITS-1:0];
  endfunction

  // One adjacent pair in iso mode. A missing neighbor only lets an exact hit
  // on the iso value through, and that hit does not end the search.
  function void iso_pair(logic [VBITS-1:0] vc, logic [VBITS-1:0] lc);
    logic m_prev, m_cur, lo_hi, hi_lo;
    m_prev = (prev_sample == miss_reg);
    m_cur  = (vc == miss_reg);
    if (m_prev && m_cur) return;
    if (m_prev && iso_reg == vc) begin
      col_result = lc;
      result_set = 1'b1;
    end
    if (m_cur && iso_reg == prev_sample) begin
      col_result = prev_level;
      result_set = 1'b1;
    end
    if (m_prev || m_cur) return;
    lo_hi = ($signed(prev_sample) <= $signed(iso_reg)) && ($signed(iso_reg) <= $signed(vc));
    hi_lo = ($signed(vc) <= $signed(iso_reg)) && ($signed(iso_reg) <= $signed(prev_sample));
    if (lo_hi || hi_lo) begin
      col_result  = (prev_sample == vc) ? prev_level
                                        : crossing_level(prev_level, prev_sample, lc, vc);
      result_set  = 1'b1;
      column_done = 1'b1;
    end
  endfunction

  // Advances the shadow state by one accepted sample beat and, at a column
  // end, queues the result the block owes for that column.
  function void predict_sample(logic [VBITS-1:0] v, logic [VBITS-1:0] l, logic col_end);
    column_result_t r;
    if (cur_mode == MODE_ISO) begin
      if (have_prev && !column_done) iso_pair(v, l);
    end else if (cur_mode == MODE_FIRST) begin
      if (!column_done && v != miss_reg) begin
        col_result  = v;
        result_set  = 1'b1;
        column_done = 1'b1;
      end
    end else if (cur_mode == MODE_LAST) begin
      if (v != miss_reg) begin
        col_result = v;
        result_set = 1'b1;
      end
    end
    prev_sample = v;
    prev_level  = l;
    have_prev   = 1'b1;
    if (col_end) begin
      r.surface = result_set ? col_result : miss_reg;
      r.found   = result_set;
      pending_columns.push_back(r);
      clear_column();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers. All tasks are entered and left at a falling edge.
  // ---------------------------------------------------------------------------

  // Sends one sample beat. Valid stays high into the next call unless that
  // call opens a gap, so back-to-back beats keep valid asserted.
  task automatic send_sample(input logic [VBITS-1:0] v, input logic [VBITS-1:0] l,
                             input logic col_end);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_sample_value <= v;
    in_level_coord  <= l;
    in_column_end   <= col_end;
    do @(posedge clk); while (in_stall);
    predict_sample(v, l, col_end);
    items_sent++;
    @(negedge clk);
  endtask

  // Holds the sample channel off until every owed result has come back, then
  // lets the block finish any divide still in flight.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_columns.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Writes one register; valid stays high so that writes can follow back to back.
  task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] idx, input logic [VBITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MODE:    cur_mode = data[1:0];
      CFG_ISO:     iso_reg  = data;
      CFG_MISSING: miss_reg = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Registers are only rewritten with the block idle and the channel drained.
  // The upper bits of the mode write carry noise that the block must ignore.
  task automatic set_config(input logic [1:0] m, input logic [VBITS-1:0] iso,
                            input logic [VBITS-1:0] miss);
    wait_drained();
    cfg_write(CFG_MODE, {30'($urandom_range(1023)), m});
    cfg_write(CFG_ISO, iso);
    cfg_write(CFG_MISSING, miss);
    cfg_valid <= 1'b0;
  endtask

  task automatic report_mismatch(input string what, input logic [VBITS-1:0] got,
                                 input logic [VBITS-1:0] want);
    $display("mismatch on %s: got %h, expected %h", what, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Result checker, receiver stalls and watchdog
  // ---------------------------------------------------------------------------

  column_result_t owed;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_columns.size() == 0) begin
        report_mismatch("unexpected result beat", out_surface_value, '0);
      end else begin
        owed = pending_columns.pop_front();
        if (out_surface_value !== owed.surface)
          report_mismatch("surface_value", out_surface_value, owed.surface);
        if (out_found !== owed.found)
          report_mismatch("found", {31'h0, out_found}, {31'h0, owed.found});
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Counts cycles in which no beat moves on any channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("[column_isosurface_level] ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // The reset registers give iso mode at zero with the most negative value as
  // the missing pattern. A rising pair from -1 to +1 crosses halfway.
  task automatic test_reset_defaults();
    send_sample(-Q_ONE, 32'h000A_0000, 1'b0);
    send_sample(Q_ONE, 32'h0014_0000, 1'b1);
  endtask

  // Iso search rules: lone sample, flat pair on the iso value, missing
  // neighbors, no crossing at all, full-scale values and levels, and a found
  // level that happens to equal the missing pattern.
  task automatic test_iso_rules();
    set_config(MODE_ISO, Q_ONE, Q_MAX);
    send_sample(Q_ONE, 32'h0005_0000, 1'b1);
    send_sample(Q_ONE, 32'h0001_0000, 1'b0);
    send_sample(Q_ONE, 32'h0002_0000, 1'b1);
    // Hits next to missing samples are taken but the search keeps going.
    send_sample(Q_MAX, 32'h0001_0000, 1'b0);
    send_sample(Q_ONE, 32'h0002_0000, 1'b0);
    send_sample(Q_MAX, 32'h0003_0000, 1'b0);
    send_sample(32'h0005_0000, 32'h0004_0000, 1'b1);
    send_sample(Q_MAX, 32'h0001_0000, 1'b0);
    send_sample(Q_MAX, 32'h0002_0000, 1'b0);
    send_sample(32'h0003_0000, 32'h0003_0000, 1'b0);
    send_sample(32'h0004_0000, 32'h0004_0000, 1'b1);
    send_sample(Q_MIN, Q_MAX, 1'b0);
    send_sample(32'h7FFF_FFFE, Q_MIN, 1'b1);
    set_config(MODE_ISO, Q_ONE, 32'h0003_0000);
    send_sample(Q_ONE, 32'h0003_0000, 1'b0);
    send_sample(32'h0002_0000, 32'h0009_0000, 1'b1);
  endtask

  // First and last value modes skip missing samples; the unused mode code and
  // an all-missing column both report the missing pattern with found low.
  task automatic test_select_modes();
    set_config(MODE_FIRST, Q_ONE, Q_MAX);
    send_sample(Q_MAX, 32'h0001_0000, 1'b0);
    send_sample(32'h0002_0000, 32'h0002_0000, 1'b0);
    send_sample(32'h0003_0000, 32'h0003_0000, 1'b1);
    send_sample(Q_MAX, 32'h0001_0000, 1'b1);
    set_config(MODE_LAST, '0, Q_MAX);
    send_sample(32'h0004_0000, 32'h0001_0000, 1'b0);
    send_sample(Q_MAX, 32'h0002_0000, 1'b1);
    set_config(MODE_UNUSED, '0, Q_MIN);
    send_sample(32'h0005_0000, 32'h0001_0000, 1'b1);
  endtask

  function logic [VBITS-1:0] pick_pattern();
    case ($urandom_range(5))
      0: return Q_MIN;
      1: return Q_MAX;
      2: return '0;
      3: return $urandom_range(1) ? Q_ONE : -Q_ONE;
      default: return $urandom();
    endcase
  endfunction

  task automatic random_config();
    logic [1:0] m;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: m = MODE_ISO;
      6, 7: m = MODE_FIRST;
      8: m = MODE_LAST;
      default: m = MODE_UNUSED;
    endcase
    set_config(m, pick_pattern(), pick_pattern());
  endtask

  // Most columns are a random walk that starts near the iso value, so they
  // cross it and exercise the interpolation; missing samples and full-scale
  // values are sprinkled in. A few columns are pure noise.
  task automatic send_random_column();
    int len, kind, i;
    logic [VBITS-1:0] walk, lvl, lstep, v, l;
    kind  = $urandom_range(9);
    len   = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    lvl   = $urandom();
    lstep = $urandom_range(1, 32'h0004_0000);
    if ($urandom_range(1)) lstep = -lstep;
    walk  = iso_reg + $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    for (i = 0; i < len; i++) begin
      if (kind < 2) begin
        v = $urandom();
      end else begin
        case ($urandom_range(19))
          0, 1: v = miss_reg;
          2: v = iso_reg;
          3: v = $urandom_range(1) ? Q_MIN : Q_MAX;
          default: begin
            walk = walk + $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
            v = walk;
          end
        endcase
      end
      l = (kind == 0 || $urandom_range(29) == 0) ? 32'($urandom()) : lvl;
      lvl = lvl + lstep;
      send_sample(v, l, i == len - 1);
    end
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
    int target;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    target = items_sent + count;
    while (items_sent < target) begin
      random_config();
      repeat ($urandom_range(6, 14)) send_random_column();
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_sample_value = '0;
    in_level_coord  = '0;
    in_column_end   = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = CFG_MODE;
    cfg_data        = '0;
    cur_mode        = MODE_ISO;
    iso_reg         = '0;
    miss_reg        = MISSING_RESET[VBITS-1:0];
    prev_sample     = '0;
    prev_level      = '0;
    clear_column();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_iso_rules();
    test_select_modes();
    test_random_traffic(25, 70, 400);
    test_random_traffic(70, 25, 400);
    test_random_traffic(0, 0, 400);

    wait_drained();
    if (mismatch_count == 0) begin
      $display("[column_isosurface_level] OK");
    end else begin
      $display("[column_isosurface_level] ERROR");
    end
    $finish;
  end

endmodule
